>>> design/ifb_pkg.sv
package ifb_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int LANE_SLOTS = 4;
	localparam int BANKS = 4;
	localparam int IN_W = 392;
	localparam int OUT_W = 456;
	localparam int ENTRY_W = 96;

	// output beat layout
	localparam int OUT_LANE_BASE = 3;
	localparam int OUT_RV_BIT = 387;
	localparam int OUT_TGT_BASE = 388;

	typedef struct packed {
		logic [63:0] pc;
		logic [31:0] word;
	} ifb_entry_t;

	// write and read steering shared by every bank lane
	typedef struct packed {
		logic       wr_en;
		logic [2:0] push_n;
		logic [1:0] tail_bank;
		logic [1:0] head_bank;
	} ifb_ctl_t;

	typedef enum logic {
		CFG_ROOM = 1'b0,
		CFG_SEND = 1'b1
	} ifb_cfg_t;

endpackage

>>> design/ifb_ram.sv
module ifb_ram import ifb_pkg::*; #(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = DEPTH_DEFAULT / BANKS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/ifb_lane.sv
module ifb_lane import ifb_pkg::*; #(
	parameter int BANK = 0,
	parameter int ROWS = DEPTH_DEFAULT / BANKS,
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic          clk,
	input  ifb_ctl_t      ctl,
	input  logic [RW-1:0] tail_row,
	input  logic [RW-1:0] head_row,
	input  ifb_entry_t    in_entry [LANE_SLOTS],
	output ifb_entry_t    rd_data
);

	localparam logic [1:0] BANK_ID = 2'(BANK);
	localparam logic [RW:0] ROWS_C = (RW+1)'(ROWS);

	logic [1:0]    wr_k;
	logic          we;
	logic [RW:0]   wr_sum;
	logic [RW-1:0] wr_row;
	logic [RW:0]   rd_sum;
	logic [RW-1:0] rd_row;
	logic [ENTRY_W-1:0] rdata;

	always_comb begin
		// which incoming lane lands in this bank
		wr_k = BANK_ID - ctl.tail_bank;
		we = ctl.wr_en && ({1'b0, wr_k} < ctl.push_n);
		wr_sum = {1'b0, tail_row} + (RW+1)'(BANK_ID < ctl.tail_bank);
		wr_row = (wr_sum == ROWS_C) ? '0 : wr_sum[RW-1:0];
		rd_sum = {1'b0, head_row} + (RW+1)'(BANK_ID < ctl.head_bank);
		rd_row = (rd_sum == ROWS_C) ? '0 : rd_sum[RW-1:0];
	end

	ifb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ROWS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wr_row),
		.wdata(in_entry[wr_k]),
		.raddr(rd_row),
		.rdata(rdata)
	);

	assign rd_data = ifb_entry_t'(rdata);

endmodule

>>> design/ifb_merge.sv
module ifb_merge import ifb_pkg::*; (
	input  ifb_entry_t        rd_data [BANKS],
	input  logic [1:0]        head_bank,
	input  logic [2:0]        count,
	input  logic              redirect_valid,
	input  logic [63:0]       redirect_target,
	output logic [OUT_W-1:0]  beat
);

	always_comb begin
		logic [1:0] idx;
		beat = '0;
		beat[2:0] = count;
		for (int k = 0; k < LANE_SLOTS; k++) begin
			idx = head_bank + 2'(k);
			// rotate banks back into fifo order, blank the unused lanes
			if (3'(k) < count) begin
				beat[OUT_LANE_BASE + ENTRY_W*k +: 64] = rd_data[idx].pc;
				beat[OUT_LANE_BASE + ENTRY_W*k + 64 +: 32] = rd_data[idx].word;
			end
		end
		beat[OUT_RV_BIT] = redirect_valid;
		beat[OUT_TGT_BASE +: 64] = redirect_target;
	end

endmodule

>>> design/instruction_fetch_buffer.sv
// Instruction buffer between fetch and decode, one pipeline cycle per beat.
// Slave stream (s_*) carries one cycle's inputs: flush, acknowledged count,
// incoming packet count and lanes, and the decode stall flag. Master stream
// (m_*) returns exactly one result beat per input beat: the presented head
// entries and a replay redirect when a packet found too little room.
// cfg_we/cfg_index/cfg_data write packet_room_needed (0) and send_width (1);
// write them only while no beat is in flight.
// An accepted beat updates the pointers and writes the banked entry store in
// the cycle it is accepted; the head entries are then read from four banks
// with a registered read, and the result is registered into the output
// register after that. The next beat is taken while the result loads, and
// only if the output register is free, so a new beat waits for the bank read.
// If m_tready stays low the result waits in the output register and the
// block holds s_tready low while the next result waits to load.
// Reset empties the buffer, clears the handshake state and sets both
// configuration registers to 4. No clearing pass: entries are only read
// inside the occupancy.
module instruction_fetch_buffer import ifb_pkg::*; #(
	parameter int BUFFER_DEPTH = DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// flush, taken_count, pkt_count, out_stalled, then in_pc_k, in_word_k for k = 0..3
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// out_count, then out_pc_k, out_word_k for k = 0..3, redirect_valid, redirect_target
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [2:0]       cfg_data
);

	localparam int ROWS = (BUFFER_DEPTH + BANKS - 1) / BANKS;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW = RW + 2;
	localparam int OW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [PW:0] PHYS = (PW+1)'(ROWS * BANKS);
	localparam logic [OW-1:0] DEPTH_C = OW'(BUFFER_DEPTH);
	localparam logic [2:0] SLOTS_C = 3'(LANE_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t state_q;
	logic [2:0] room_q;
	logic [2:0] send_q;
	logic [PW-1:0] head_q;
	logic [OW-1:0] occ_q;
	logic [2:0] n_q;
	logic redir_q;
	logic [63:0] target_q;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic in_flush;
	logic [2:0] in_taken;
	logic [2:0] in_pkt;
	logic in_stalled;
	ifb_entry_t in_entry [LANE_SLOTS];

	logic accept;
	logic out_free;
	logic [OW-1:0] pop_n;
	logic [OW-1:0] occ_pop;
	logic [PW:0] head_sum;
	logic [PW-1:0] head_pop;
	logic [PW:0] tail_sum;
	logic [PW-1:0] tail_ptr;
	logic [2:0] cnt;
	logic [OW-1:0] free_n;
	logic [2:0] push_n;
	logic redir;
	logic [OW-1:0] occ_new;
	logic [2:0] sw;
	logic [2:0] n;
	logic [PW-1:0] head_nxt;
	logic [OW-1:0] occ_nxt;

	ifb_ctl_t ctl;
	ifb_entry_t rd_data [BANKS];
	logic [OUT_W-1:0] beat;

	assign in_flush = s_tdata[0];
	assign in_taken = s_tdata[3:1];
	assign in_pkt = s_tdata[6:4];
	assign in_stalled = s_tdata[7];

	always_comb begin
		for (int k = 0; k < LANE_SLOTS; k++) begin
			in_entry[k].pc = s_tdata[8 + ENTRY_W*k +: 64];
			in_entry[k].word = s_tdata[72 + ENTRY_W*k +: 32];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) || ((state_q == ST_LOAD) && out_free);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		// pop, saturated at the occupancy
		pop_n = (OW'(in_taken) > occ_q) ? occ_q : OW'(in_taken);
		occ_pop = occ_q - pop_n;
		head_sum = {1'b0, head_q} + (PW+1)'(pop_n);
		head_pop = (head_sum >= PHYS) ? PW'(head_sum - PHYS) : head_sum[PW-1:0];
		tail_sum = {1'b0, head_pop} + (PW+1)'(occ_pop);
		tail_ptr = (tail_sum >= PHYS) ? PW'(tail_sum - PHYS) : tail_sum[PW-1:0];

		// push or replay
		cnt = (in_pkt > SLOTS_C) ? SLOTS_C : in_pkt;
		free_n = DEPTH_C - occ_pop;
		push_n = '0;
		redir = 1'b0;
		if (cnt != '0) begin
			if (free_n >= OW'(room_q)) begin
				push_n = (OW'(cnt) > free_n) ? free_n[2:0] : cnt;
			end else begin
				redir = 1'b1;
			end
		end
		occ_new = occ_pop + OW'(push_n);

		// present
		sw = (send_q > SLOTS_C) ? SLOTS_C : send_q;
		n = (OW'(sw) > occ_new) ? occ_new[2:0] : sw;
		if (in_stalled) begin
			n = '0;
		end

		head_nxt = head_pop;
		occ_nxt = occ_new;
		if (in_flush) begin
			push_n = '0;
			redir = 1'b0;
			n = '0;
			head_nxt = '0;
			occ_nxt = '0;
		end

		ctl.wr_en = accept && !in_flush;
		ctl.push_n = push_n;
		ctl.tail_bank = tail_ptr[1:0];
		ctl.head_bank = head_q[1:0];
	end

	for (genvar b = 0; b < BANKS; b++) begin : g_lane
		ifb_lane #(
			.BANK(b),
			.ROWS(ROWS)
		) u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.tail_row(tail_ptr[PW-1:2]),
			.head_row(head_q[PW-1:2]),
			.in_entry(in_entry),
			.rd_data (rd_data[b])
		);
	end

	ifb_merge u_merge (
		.rd_data        (rd_data),
		.head_bank      (head_q[1:0]),
		.count          (n_q),
		.redirect_valid (redir_q),
		.redirect_target(target_q),
		.beat           (beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q <= 3'd4;
			send_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (ifb_cfg_t'(cfg_index))
				CFG_ROOM: room_q <= cfg_data;
				CFG_SEND: send_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			occ_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= head_nxt;
				occ_q <= occ_nxt;
			end
			if ((state_q == ST_LOAD) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (out_free) begin
						state_q <= accept ? ST_READ : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n;
			redir_q <= redir;
			target_q <= redir ? in_entry[0].pc : '0;
		end
		if ((state_q == ST_LOAD) && out_free) begin
			m_tdata_q <= beat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule
